// File: sv/sgsg_pkg.sv
// shared types, constants and glyph segment rom for the stroke glyph segment generator
package sgsg_pkg;

	localparam int XS_W = 21;
	localparam int Y_W = 4;
	localparam int SEG_IDX_W = 4;
	localparam int GLYPH_W = 7;
	localparam int ROM_ADDR_W = GLYPH_W + SEG_IDX_W;
	localparam int MAX_SEGS = 16;
	localparam logic [7:0] ADVANCE_RESET = 8'd96;

	// one rom word: x0,y0,x1,y1 (x 3 bits unsigned, y 4 bits signed), last flag
	typedef struct packed {
		logic [2:0]     x0;
		logic [Y_W-1:0] y0;
		logic [2:0]     x1;
		logic [Y_W-1:0] y1;
		logic           last;
	} seg_t;

	// per-glyph directory entry: glyph number (the upper rom address bits) and segment count
	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [4:0]         nseg;
	} dir_t;

	// segment packing helper
	function automatic seg_t mk(input int x0, input int y0, input int x1, input int y1,
			input logic lst);
		seg_t s;
		s.x0 = 3'(x0);
		s.y0 = 4'(y0);
		s.x1 = 3'(x1);
		s.y1 = 4'(y1);
		s.last = lst;
		return s;
	endfunction

	// glyph number for a character code, 0 is the box
	function automatic dir_t glyph_dir(input logic [7:0] code);
		dir_t d;
		d.glyph = '0;
		d.nseg = 5'd4;
		case (code)
			8'h20: begin d.glyph = 7'd1;  d.nseg = 5'd0;  end
			8'h41: begin d.glyph = 7'd2;  d.nseg = 5'd5;  end
			8'h42: begin d.glyph = 7'd3;  d.nseg = 5'd10; end
			8'h43: begin d.glyph = 7'd4;  d.nseg = 5'd7;  end
			8'h44: begin d.glyph = 7'd5;  d.nseg = 5'd6;  end
			8'h45: begin d.glyph = 7'd6;  d.nseg = 5'd4;  end
			8'h46: begin d.glyph = 7'd7;  d.nseg = 5'd3;  end
			8'h47: begin d.glyph = 7'd8;  d.nseg = 5'd9;  end
			8'h48: begin d.glyph = 7'd9;  d.nseg = 5'd3;  end
			8'h49: begin d.glyph = 7'd10; d.nseg = 5'd3;  end
			8'h4A: begin d.glyph = 7'd11; d.nseg = 5'd4;  end
			8'h4B: begin d.glyph = 7'd12; d.nseg = 5'd3;  end
			8'h4C: begin d.glyph = 7'd13; d.nseg = 5'd2;  end
			8'h4D: begin d.glyph = 7'd14; d.nseg = 5'd4;  end
			8'h4E: begin d.glyph = 7'd15; d.nseg = 5'd3;  end
			8'h4F: begin d.glyph = 7'd16; d.nseg = 5'd8;  end
			8'h50: begin d.glyph = 7'd17; d.nseg = 5'd6;  end
			8'h51: begin d.glyph = 7'd18; d.nseg = 5'd9;  end
			8'h52: begin d.glyph = 7'd19; d.nseg = 5'd7;  end
			8'h53: begin d.glyph = 7'd20; d.nseg = 5'd11; end
			8'h54: begin d.glyph = 7'd21; d.nseg = 5'd2;  end
			8'h55: begin d.glyph = 7'd22; d.nseg = 5'd5;  end
			8'h56: begin d.glyph = 7'd23; d.nseg = 5'd2;  end
			8'h57: begin d.glyph = 7'd24; d.nseg = 5'd4;  end
			8'h58: begin d.glyph = 7'd25; d.nseg = 5'd2;  end
			8'h59: begin d.glyph = 7'd26; d.nseg = 5'd3;  end
			8'h5A: begin d.glyph = 7'd27; d.nseg = 5'd3;  end
			8'h61: begin d.glyph = 7'd28; d.nseg = 5'd8;  end
			8'h62: begin d.glyph = 7'd29; d.nseg = 5'd8;  end
			8'h63: begin d.glyph = 7'd30; d.nseg = 5'd7;  end
			8'h64: begin d.glyph = 7'd31; d.nseg = 5'd8;  end
			8'h65: begin d.glyph = 7'd32; d.nseg = 5'd9;  end
			8'h66: begin d.glyph = 7'd33; d.nseg = 5'd4;  end
			8'h67: begin d.glyph = 7'd34; d.nseg = 5'd12; end
			8'h68: begin d.glyph = 7'd35; d.nseg = 5'd5;  end
			8'h69: begin d.glyph = 7'd36; d.nseg = 5'd2;  end
			8'h6A: begin d.glyph = 7'd37; d.nseg = 5'd4;  end
			8'h6B: begin d.glyph = 7'd38; d.nseg = 5'd3;  end
			8'h6C: begin d.glyph = 7'd39; d.nseg = 5'd3;  end
			8'h6D: begin d.glyph = 7'd40; d.nseg = 5'd7;  end
			8'h6E: begin d.glyph = 7'd41; d.nseg = 5'd5;  end
			8'h6F: begin d.glyph = 7'd42; d.nseg = 5'd8;  end
			8'h70: begin d.glyph = 7'd43; d.nseg = 5'd8;  end
			8'h71: begin d.glyph = 7'd44; d.nseg = 5'd8;  end
			8'h72: begin d.glyph = 7'd45; d.nseg = 5'd4;  end
			8'h73: begin d.glyph = 7'd46; d.nseg = 5'd9;  end
			8'h74: begin d.glyph = 7'd47; d.nseg = 5'd4;  end
			8'h75: begin d.glyph = 7'd48; d.nseg = 5'd5;  end
			8'h76: begin d.glyph = 7'd49; d.nseg = 5'd2;  end
			8'h77: begin d.glyph = 7'd50; d.nseg = 5'd4;  end
			8'h78: begin d.glyph = 7'd51; d.nseg = 5'd2;  end
			8'h79: begin d.glyph = 7'd52; d.nseg = 5'd3;  end
			8'h7A: begin d.glyph = 7'd53; d.nseg = 5'd3;  end
			8'h30: begin d.glyph = 7'd54; d.nseg = 5'd9;  end
			8'h31: begin d.glyph = 7'd55; d.nseg = 5'd3;  end
			8'h32: begin d.glyph = 7'd56; d.nseg = 5'd6;  end
			8'h33: begin d.glyph = 7'd57; d.nseg = 5'd11; end
			8'h34: begin d.glyph = 7'd58; d.nseg = 5'd3;  end
			8'h35: begin d.glyph = 7'd59; d.nseg = 5'd8;  end
			8'h36: begin d.glyph = 7'd60; d.nseg = 5'd9;  end
			8'h37: begin d.glyph = 7'd61; d.nseg = 5'd2;  end
			8'h38: begin d.glyph = 7'd62; d.nseg = 5'd15; end
			8'h39: begin d.glyph = 7'd63; d.nseg = 5'd9;  end
			8'h2D: begin d.glyph = 7'd64; d.nseg = 5'd1;  end
			8'h2E: begin d.glyph = 7'd65; d.nseg = 5'd1;  end
			8'h2C: begin d.glyph = 7'd66; d.nseg = 5'd1;  end
			8'h27: begin d.glyph = 7'd67; d.nseg = 5'd1;  end
			8'h3A: begin d.glyph = 7'd68; d.nseg = 5'd2;  end
			default: begin d.glyph = 7'd0; d.nseg = 5'd4; end
		endcase
		return d;
	endfunction

	// segment k of glyph g; each rom word holds both endpoints of its segment
	function automatic seg_t seg_rom(input logic [ROM_ADDR_W-1:0] a);
		logic [GLYPH_W-1:0] g;
		logic [SEG_IDX_W-1:0] k;
		seg_t s;
		g = a[ROM_ADDR_W-1:SEG_IDX_W];
		k = a[SEG_IDX_W-1:0];
		s = '0;
		case ({g, k})
			// box
			{7'd0, 4'd0}: s = mk(0,0,4,0,0);
			{7'd0, 4'd1}: s = mk(4,0,4,6,0);
			{7'd0, 4'd2}: s = mk(4,6,0,6,0);
			{7'd0, 4'd3}: s = mk(0,6,0,0,1);
			// A
			{7'd2, 4'd0}: s = mk(0,0,0,4,0);
			{7'd2, 4'd1}: s = mk(0,4,2,6,0);
			{7'd2, 4'd2}: s = mk(2,6,4,4,0);
			{7'd2, 4'd3}: s = mk(4,4,4,0,0);
			{7'd2, 4'd4}: s = mk(0,3,4,3,1);
			// B
			{7'd3, 4'd0}: s = mk(0,0,0,6,0);
			{7'd3, 4'd1}: s = mk(0,6,3,6,0);
			{7'd3, 4'd2}: s = mk(3,6,4,5,0);
			{7'd3, 4'd3}: s = mk(4,5,4,4,0);
			{7'd3, 4'd4}: s = mk(4,4,3,3,0);
			{7'd3, 4'd5}: s = mk(3,3,0,3,0);
			{7'd3, 4'd6}: s = mk(3,3,4,2,0);
			{7'd3, 4'd7}: s = mk(4,2,4,1,0);
			{7'd3, 4'd8}: s = mk(4,1,3,0,0);
			{7'd3, 4'd9}: s = mk(3,0,0,0,1);
			// C
			{7'd4, 4'd0}: s = mk(4,5,3,6,0);
			{7'd4, 4'd1}: s = mk(3,6,1,6,0);
			{7'd4, 4'd2}: s = mk(1,6,0,5,0);
			{7'd4, 4'd3}: s = mk(0,5,0,1,0);
			{7'd4, 4'd4}: s = mk(0,1,1,0,0);
			{7'd4, 4'd5}: s = mk(1,0,3,0,0);
			{7'd4, 4'd6}: s = mk(3,0,4,1,1);
			// D
			{7'd5, 4'd0}: s = mk(0,0,0,6,0);
			{7'd5, 4'd1}: s = mk(0,6,3,6,0);
			{7'd5, 4'd2}: s = mk(3,6,4,5,0);
			{7'd5, 4'd3}: s = mk(4,5,4,1,0);
			{7'd5, 4'd4}: s = mk(4,1,3,0,0);
			{7'd5, 4'd5}: s = mk(3,0,0,0,1);
			// E
			{7'd6, 4'd0}: s = mk(4,6,0,6,0);
			{7'd6, 4'd1}: s = mk(0,6,0,0,0);
			{7'd6, 4'd2}: s = mk(0,0,4,0,0);
			{7'd6, 4'd3}: s = mk(0,3,3,3,1);
			// F
			{7'd7, 4'd0}: s = mk(4,6,0,6,0);
			{7'd7, 4'd1}: s = mk(0,6,0,0,0);
			{7'd7, 4'd2}: s = mk(0,3,3,3,1);
			// G
			{7'd8, 4'd0}: s = mk(4,5,3,6,0);
			{7'd8, 4'd1}: s = mk(3,6,1,6,0);
			{7'd8, 4'd2}: s = mk(1,6,0,5,0);
			{7'd8, 4'd3}: s = mk(0,5,0,1,0);
			{7'd8, 4'd4}: s = mk(0,1,1,0,0);
			{7'd8, 4'd5}: s = mk(1,0,3,0,0);
			{7'd8, 4'd6}: s = mk(3,0,4,1,0);
			{7'd8, 4'd7}: s = mk(4,1,4,3,0);
			{7'd8, 4'd8}: s = mk(4,3,2,3,1);
			// H
			{7'd9, 4'd0}: s = mk(0,0,0,6,0);
			{7'd9, 4'd1}: s = mk(4,0,4,6,0);
			{7'd9, 4'd2}: s = mk(0,3,4,3,1);
			// I
			{7'd10, 4'd0}: s = mk(1,6,3,6,0);
			{7'd10, 4'd1}: s = mk(2,6,2,0,0);
			{7'd10, 4'd2}: s = mk(1,0,3,0,1);
			// J
			{7'd11, 4'd0}: s = mk(0,1,1,0,0);
			{7'd11, 4'd1}: s = mk(1,0,3,0,0);
			{7'd11, 4'd2}: s = mk(3,0,4,1,0);
			{7'd11, 4'd3}: s = mk(4,1,4,6,1);
			// K
			{7'd12, 4'd0}: s = mk(0,0,0,6,0);
			{7'd12, 4'd1}: s = mk(4,6,0,3,0);
			{7'd12, 4'd2}: s = mk(0,3,4,0,1);
			// L
			{7'd13, 4'd0}: s = mk(0,6,0,0,0);
			{7'd13, 4'd1}: s = mk(0,0,4,0,1);
			// M
			{7'd14, 4'd0}: s = mk(0,0,0,6,0);
			{7'd14, 4'd1}: s = mk(0,6,2,3,0);
			{7'd14, 4'd2}: s = mk(2,3,4,6,0);
			{7'd14, 4'd3}: s = mk(4,6,4,0,1);
			// N
			{7'd15, 4'd0}: s = mk(0,0,0,6,0);
			{7'd15, 4'd1}: s = mk(0,6,4,0,0);
			{7'd15, 4'd2}: s = mk(4,0,4,6,1);
			// O
			{7'd16, 4'd0}: s = mk(1,0,3,0,0);
			{7'd16, 4'd1}: s = mk(3,0,4,1,0);
			{7'd16, 4'd2}: s = mk(4,1,4,5,0);
			{7'd16, 4'd3}: s = mk(4,5,3,6,0);
			{7'd16, 4'd4}: s = mk(3,6,1,6,0);
			{7'd16, 4'd5}: s = mk(1,6,0,5,0);
			{7'd16, 4'd6}: s = mk(0,5,0,1,0);
			{7'd16, 4'd7}: s = mk(0,1,1,0,1);
			// P
			{7'd17, 4'd0}: s = mk(0,0,0,6,0);
			{7'd17, 4'd1}: s = mk(0,6,3,6,0);
			{7'd17, 4'd2}: s = mk(3,6,4,5,0);
			{7'd17, 4'd3}: s = mk(4,5,4,4,0);
			{7'd17, 4'd4}: s = mk(4,4,3,3,0);
			{7'd17, 4'd5}: s = mk(3,3,0,3,1);
			// Q
			{7'd18, 4'd0}: s = mk(1,0,3,0,0);
			{7'd18, 4'd1}: s = mk(3,0,4,1,0);
			{7'd18, 4'd2}: s = mk(4,1,4,5,0);
			{7'd18, 4'd3}: s = mk(4,5,3,6,0);
			{7'd18, 4'd4}: s = mk(3,6,1,6,0);
			{7'd18, 4'd5}: s = mk(1,6,0,5,0);
			{7'd18, 4'd6}: s = mk(0,5,0,1,0);
			{7'd18, 4'd7}: s = mk(0,1,1,0,0);
			{7'd18, 4'd8}: s = mk(2,2,4,-1,1);
			// R
			{7'd19, 4'd0}: s = mk(0,0,0,6,0);
			{7'd19, 4'd1}: s = mk(0,6,3,6,0);
			{7'd19, 4'd2}: s = mk(3,6,4,5,0);
			{7'd19, 4'd3}: s = mk(4,5,4,4,0);
			{7'd19, 4'd4}: s = mk(4,4,3,3,0);
			{7'd19, 4'd5}: s = mk(3,3,0,3,0);
			{7'd19, 4'd6}: s = mk(2,3,4,0,1);
			// S
			{7'd20, 4'd0}: s = mk(4,5,3,6,0);
			{7'd20, 4'd1}: s = mk(3,6,1,6,0);
			{7'd20, 4'd2}: s = mk(1,6,0,5,0);
			{7'd20, 4'd3}: s = mk(0,5,0,4,0);
			{7'd20, 4'd4}: s = mk(0,4,1,3,0);
			{7'd20, 4'd5}: s = mk(1,3,3,3,0);
			{7'd20, 4'd6}: s = mk(3,3,4,2,0);
			{7'd20, 4'd7}: s = mk(4,2,4,1,0);
			{7'd20, 4'd8}: s = mk(4,1,3,0,0);
			{7'd20, 4'd9}: s = mk(3,0,1,0,0);
			{7'd20, 4'd10}: s = mk(1,0,0,1,1);
			// T
			{7'd21, 4'd0}: s = mk(0,6,4,6,0);
			{7'd21, 4'd1}: s = mk(2,6,2,0,1);
			// U
			{7'd22, 4'd0}: s = mk(0,6,0,1,0);
			{7'd22, 4'd1}: s = mk(0,1,1,0,0);
			{7'd22, 4'd2}: s = mk(1,0,3,0,0);
			{7'd22, 4'd3}: s = mk(3,0,4,1,0);
			{7'd22, 4'd4}: s = mk(4,1,4,6,1);
			// V
			{7'd23, 4'd0}: s = mk(0,6,2,0,0);
			{7'd23, 4'd1}: s = mk(2,0,4,6,1);
			// W
			{7'd24, 4'd0}: s = mk(0,6,0,0,0);
			{7'd24, 4'd1}: s = mk(0,0,2,3,0);
			{7'd24, 4'd2}: s = mk(2,3,4,0,0);
			{7'd24, 4'd3}: s = mk(4,0,4,6,1);
			// X
			{7'd25, 4'd0}: s = mk(0,6,4,0,0);
			{7'd25, 4'd1}: s = mk(0,0,4,6,1);
			// Y
			{7'd26, 4'd0}: s = mk(0,6,2,3,0);
			{7'd26, 4'd1}: s = mk(2,3,4,6,0);
			{7'd26, 4'd2}: s = mk(2,3,2,0,1);
			// Z
			{7'd27, 4'd0}: s = mk(0,6,4,6,0);
			{7'd27, 4'd1}: s = mk(4,6,0,0,0);
			{7'd27, 4'd2}: s = mk(0,0,4,0,1);
			// a
			{7'd28, 4'd0}: s = mk(4,0,4,4,0);
			{7'd28, 4'd1}: s = mk(4,3,3,4,0);
			{7'd28, 4'd2}: s = mk(3,4,1,4,0);
			{7'd28, 4'd3}: s = mk(1,4,0,3,0);
			{7'd28, 4'd4}: s = mk(0,3,0,1,0);
			{7'd28, 4'd5}: s = mk(0,1,1,0,0);
			{7'd28, 4'd6}: s = mk(1,0,3,0,0);
			{7'd28, 4'd7}: s = mk(3,0,4,1,1);
			// b
			{7'd29, 4'd0}: s = mk(0,0,0,6,0);
			{7'd29, 4'd1}: s = mk(0,3,2,4,0);
			{7'd29, 4'd2}: s = mk(2,4,3,4,0);
			{7'd29, 4'd3}: s = mk(3,4,4,3,0);
			{7'd29, 4'd4}: s = mk(4,3,4,1,0);
			{7'd29, 4'd5}: s = mk(4,1,3,0,0);
			{7'd29, 4'd6}: s = mk(3,0,1,0,0);
			{7'd29, 4'd7}: s = mk(1,0,0,1,1);
			// c
			{7'd30, 4'd0}: s = mk(4,3,3,4,0);
			{7'd30, 4'd1}: s = mk(3,4,1,4,0);
			{7'd30, 4'd2}: s = mk(1,4,0,3,0);
			{7'd30, 4'd3}: s = mk(0,3,0,1,0);
			{7'd30, 4'd4}: s = mk(0,1,1,0,0);
			{7'd30, 4'd5}: s = mk(1,0,3,0,0);
			{7'd30, 4'd6}: s = mk(3,0,4,1,1);
			// d
			{7'd31, 4'd0}: s = mk(4,0,4,6,0);
			{7'd31, 4'd1}: s = mk(4,3,2,4,0);
			{7'd31, 4'd2}: s = mk(2,4,1,4,0);
			{7'd31, 4'd3}: s = mk(1,4,0,3,0);
			{7'd31, 4'd4}: s = mk(0,3,0,1,0);
			{7'd31, 4'd5}: s = mk(0,1,1,0,0);
			{7'd31, 4'd6}: s = mk(1,0,3,0,0);
			{7'd31, 4'd7}: s = mk(3,0,4,1,1);
			// e
			{7'd32, 4'd0}: s = mk(0,2,4,2,0);
			{7'd32, 4'd1}: s = mk(4,2,4,3,0);
			{7'd32, 4'd2}: s = mk(4,3,3,4,0);
			{7'd32, 4'd3}: s = mk(3,4,1,4,0);
			{7'd32, 4'd4}: s = mk(1,4,0,3,0);
			{7'd32, 4'd5}: s = mk(0,3,0,1,0);
			{7'd32, 4'd6}: s = mk(0,1,1,0,0);
			{7'd32, 4'd7}: s = mk(1,0,3,0,0);
			{7'd32, 4'd8}: s = mk(3,0,4,1,1);
			// f
			{7'd33, 4'd0}: s = mk(1,0,1,5,0);
			{7'd33, 4'd1}: s = mk(1,5,2,6,0);
			{7'd33, 4'd2}: s = mk(2,6,3,6,0);
			{7'd33, 4'd3}: s = mk(0,3,3,3,1);
			// g
			{7'd34, 4'd0}: s = mk(4,1,3,0,0);
			{7'd34, 4'd1}: s = mk(3,0,1,0,0);
			{7'd34, 4'd2}: s = mk(1,0,0,1,0);
			{7'd34, 4'd3}: s = mk(0,1,0,3,0);
			{7'd34, 4'd4}: s = mk(0,3,1,4,0);
			{7'd34, 4'd5}: s = mk(1,4,3,4,0);
			{7'd34, 4'd6}: s = mk(3,4,4,3,0);
			{7'd34, 4'd7}: s = mk(4,3,4,1,0);
			{7'd34, 4'd8}: s = mk(4,1,4,-1,0);
			{7'd34, 4'd9}: s = mk(4,-1,3,-2,0);
			{7'd34, 4'd10}: s = mk(3,-2,1,-2,0);
			{7'd34, 4'd11}: s = mk(1,-2,0,-1,1);
			// h
			{7'd35, 4'd0}: s = mk(0,0,0,6,0);
			{7'd35, 4'd1}: s = mk(0,3,2,4,0);
			{7'd35, 4'd2}: s = mk(2,4,3,4,0);
			{7'd35, 4'd3}: s = mk(3,4,4,3,0);
			{7'd35, 4'd4}: s = mk(4,3,4,0,1);
			// i
			{7'd36, 4'd0}: s = mk(2,0,2,4,0);
			{7'd36, 4'd1}: s = mk(2,5,2,6,1);
			// j
			{7'd37, 4'd0}: s = mk(1,-1,2,-2,0);
			{7'd37, 4'd1}: s = mk(2,-2,3,-2,0);
			{7'd37, 4'd2}: s = mk(3,-2,3,4,0);
			{7'd37, 4'd3}: s = mk(3,5,3,6,1);
			// k
			{7'd38, 4'd0}: s = mk(0,0,0,6,0);
			{7'd38, 4'd1}: s = mk(3,4,0,2,0);
			{7'd38, 4'd2}: s = mk(1,2,4,0,1);
			// l
			{7'd39, 4'd0}: s = mk(1,6,2,6,0);
			{7'd39, 4'd1}: s = mk(2,6,2,0,0);
			{7'd39, 4'd2}: s = mk(2,0,3,0,1);
			// m
			{7'd40, 4'd0}: s = mk(0,0,0,4,0);
			{7'd40, 4'd1}: s = mk(0,3,1,4,0);
			{7'd40, 4'd2}: s = mk(1,4,2,3,0);
			{7'd40, 4'd3}: s = mk(2,3,2,0,0);
			{7'd40, 4'd4}: s = mk(2,3,3,4,0);
			{7'd40, 4'd5}: s = mk(3,4,4,3,0);
			{7'd40, 4'd6}: s = mk(4,3,4,0,1);
			// n
			{7'd41, 4'd0}: s = mk(0,0,0,4,0);
			{7'd41, 4'd1}: s = mk(0,3,2,4,0);
			{7'd41, 4'd2}: s = mk(2,4,3,4,0);
			{7'd41, 4'd3}: s = mk(3,4,4,3,0);
			{7'd41, 4'd4}: s = mk(4,3,4,0,1);
			// o
			{7'd42, 4'd0}: s = mk(1,0,3,0,0);
			{7'd42, 4'd1}: s = mk(3,0,4,1,0);
			{7'd42, 4'd2}: s = mk(4,1,4,3,0);
			{7'd42, 4'd3}: s = mk(4,3,3,4,0);
			{7'd42, 4'd4}: s = mk(3,4,1,4,0);
			{7'd42, 4'd5}: s = mk(1,4,0,3,0);
			{7'd42, 4'd6}: s = mk(0,3,0,1,0);
			{7'd42, 4'd7}: s = mk(0,1,1,0,1);
			// p
			{7'd43, 4'd0}: s = mk(0,-2,0,4,0);
			{7'd43, 4'd1}: s = mk(0,3,2,4,0);
			{7'd43, 4'd2}: s = mk(2,4,3,4,0);
			{7'd43, 4'd3}: s = mk(3,4,4,3,0);
			{7'd43, 4'd4}: s = mk(4,3,4,1,0);
			{7'd43, 4'd5}: s = mk(4,1,3,0,0);
			{7'd43, 4'd6}: s = mk(3,0,1,0,0);
			{7'd43, 4'd7}: s = mk(1,0,0,1,1);
			// q
			{7'd44, 4'd0}: s = mk(4,-2,4,4,0);
			{7'd44, 4'd1}: s = mk(4,3,2,4,0);
			{7'd44, 4'd2}: s = mk(2,4,1,4,0);
			{7'd44, 4'd3}: s = mk(1,4,0,3,0);
			{7'd44, 4'd4}: s = mk(0,3,0,1,0);
			{7'd44, 4'd5}: s = mk(0,1,1,0,0);
			{7'd44, 4'd6}: s = mk(1,0,3,0,0);
			{7'd44, 4'd7}: s = mk(3,0,4,1,1);
			// r
			{7'd45, 4'd0}: s = mk(0,0,0,4,0);
			{7'd45, 4'd1}: s = mk(0,3,2,4,0);
			{7'd45, 4'd2}: s = mk(2,4,3,4,0);
			{7'd45, 4'd3}: s = mk(3,4,4,3,1);
			// s
			{7'd46, 4'd0}: s = mk(4,3,3,4,0);
			{7'd46, 4'd1}: s = mk(3,4,1,4,0);
			{7'd46, 4'd2}: s = mk(1,4,0,3,0);
			{7'd46, 4'd3}: s = mk(0,3,1,2,0);
			{7'd46, 4'd4}: s = mk(1,2,3,2,0);
			{7'd46, 4'd5}: s = mk(3,2,4,1,0);
			{7'd46, 4'd6}: s = mk(4,1,3,0,0);
			{7'd46, 4'd7}: s = mk(3,0,1,0,0);
			{7'd46, 4'd8}: s = mk(1,0,0,1,1);
			// t
			{7'd47, 4'd0}: s = mk(1,6,1,1,0);
			{7'd47, 4'd1}: s = mk(1,1,2,0,0);
			{7'd47, 4'd2}: s = mk(2,0,3,0,0);
			{7'd47, 4'd3}: s = mk(0,4,3,4,1);
			// u
			{7'd48, 4'd0}: s = mk(0,4,0,1,0);
			{7'd48, 4'd1}: s = mk(0,1,1,0,0);
			{7'd48, 4'd2}: s = mk(1,0,3,0,0);
			{7'd48, 4'd3}: s = mk(3,0,4,1,0);
			{7'd48, 4'd4}: s = mk(4,1,4,4,1);
			// v
			{7'd49, 4'd0}: s = mk(0,4,2,0,0);
			{7'd49, 4'd1}: s = mk(2,0,4,4,1);
			// w
			{7'd50, 4'd0}: s = mk(0,4,1,0,0);
			{7'd50, 4'd1}: s = mk(1,0,2,2,0);
			{7'd50, 4'd2}: s = mk(2,2,3,0,0);
			{7'd50, 4'd3}: s = mk(3,0,4,4,1);
			// x
			{7'd51, 4'd0}: s = mk(0,4,4,0,0);
			{7'd51, 4'd1}: s = mk(0,0,4,4,1);
			// y
			{7'd52, 4'd0}: s = mk(0,4,2,1,0);
			{7'd52, 4'd1}: s = mk(2,1,4,4,0);
			{7'd52, 4'd2}: s = mk(2,1,1,-2,1);
			// z
			{7'd53, 4'd0}: s = mk(0,4,4,4,0);
			{7'd53, 4'd1}: s = mk(4,4,0,0,0);
			{7'd53, 4'd2}: s = mk(0,0,4,0,1);
			// 0
			{7'd54, 4'd0}: s = mk(1,0,3,0,0);
			{7'd54, 4'd1}: s = mk(3,0,4,1,0);
			{7'd54, 4'd2}: s = mk(4,1,4,5,0);
			{7'd54, 4'd3}: s = mk(4,5,3,6,0);
			{7'd54, 4'd4}: s = mk(3,6,1,6,0);
			{7'd54, 4'd5}: s = mk(1,6,0,5,0);
			{7'd54, 4'd6}: s = mk(0,5,0,1,0);
			{7'd54, 4'd7}: s = mk(0,1,1,0,0);
			{7'd54, 4'd8}: s = mk(0,1,4,5,1);
			// 1
			{7'd55, 4'd0}: s = mk(1,5,2,6,0);
			{7'd55, 4'd1}: s = mk(2,6,2,0,0);
			{7'd55, 4'd2}: s = mk(1,0,3,0,1);
			// 2
			{7'd56, 4'd0}: s = mk(0,5,1,6,0);
			{7'd56, 4'd1}: s = mk(1,6,3,6,0);
			{7'd56, 4'd2}: s = mk(3,6,4,5,0);
			{7'd56, 4'd3}: s = mk(4,5,4,4,0);
			{7'd56, 4'd4}: s = mk(4,4,0,0,0);
			{7'd56, 4'd5}: s = mk(0,0,4,0,1);
			// 3
			{7'd57, 4'd0}: s = mk(0,5,1,6,0);
			{7'd57, 4'd1}: s = mk(1,6,3,6,0);
			{7'd57, 4'd2}: s = mk(3,6,4,5,0);
			{7'd57, 4'd3}: s = mk(4,5,4,4,0);
			{7'd57, 4'd4}: s = mk(4,4,3,3,0);
			{7'd57, 4'd5}: s = mk(3,3,1,3,0);
			{7'd57, 4'd6}: s = mk(3,3,4,2,0);
			{7'd57, 4'd7}: s = mk(4,2,4,1,0);
			{7'd57, 4'd8}: s = mk(4,1,3,0,0);
			{7'd57, 4'd9}: s = mk(3,0,1,0,0);
			{7'd57, 4'd10}: s = mk(1,0,0,1,1);
			// 4
			{7'd58, 4'd0}: s = mk(3,0,3,6,0);
			{7'd58, 4'd1}: s = mk(0,2,4,2,0);
			{7'd58, 4'd2}: s = mk(0,2,3,6,1);
			// 5
			{7'd59, 4'd0}: s = mk(4,6,0,6,0);
			{7'd59, 4'd1}: s = mk(0,6,0,3,0);
			{7'd59, 4'd2}: s = mk(0,3,3,3,0);
			{7'd59, 4'd3}: s = mk(3,3,4,2,0);
			{7'd59, 4'd4}: s = mk(4,2,4,1,0);
			{7'd59, 4'd5}: s = mk(4,1,3,0,0);
			{7'd59, 4'd6}: s = mk(3,0,1,0,0);
			{7'd59, 4'd7}: s = mk(1,0,0,1,1);
			// 6
			{7'd60, 4'd0}: s = mk(3,6,1,6,0);
			{7'd60, 4'd1}: s = mk(1,6,0,5,0);
			{7'd60, 4'd2}: s = mk(0,5,0,1,0);
			{7'd60, 4'd3}: s = mk(0,1,1,0,0);
			{7'd60, 4'd4}: s = mk(1,0,3,0,0);
			{7'd60, 4'd5}: s = mk(3,0,4,1,0);
			{7'd60, 4'd6}: s = mk(4,1,4,2,0);
			{7'd60, 4'd7}: s = mk(4,2,3,3,0);
			{7'd60, 4'd8}: s = mk(3,3,0,3,1);
			// 7
			{7'd61, 4'd0}: s = mk(0,6,4,6,0);
			{7'd61, 4'd1}: s = mk(4,6,1,0,1);
			// 8
			{7'd62, 4'd0}: s = mk(1,3,0,4,0);
			{7'd62, 4'd1}: s = mk(0,4,0,5,0);
			{7'd62, 4'd2}: s = mk(0,5,1,6,0);
			{7'd62, 4'd3}: s = mk(1,6,3,6,0);
			{7'd62, 4'd4}: s = mk(3,6,4,5,0);
			{7'd62, 4'd5}: s = mk(4,5,4,4,0);
			{7'd62, 4'd6}: s = mk(4,4,3,3,0);
			{7'd62, 4'd7}: s = mk(3,3,1,3,0);
			{7'd62, 4'd8}: s = mk(1,3,0,2,0);
			{7'd62, 4'd9}: s = mk(0,2,0,1,0);
			{7'd62, 4'd10}: s = mk(0,1,1,0,0);
			{7'd62, 4'd11}: s = mk(1,0,3,0,0);
			{7'd62, 4'd12}: s = mk(3,0,4,1,0);
			{7'd62, 4'd13}: s = mk(4,1,4,2,0);
			{7'd62, 4'd14}: s = mk(4,2,3,3,1);
			// 9
			{7'd63, 4'd0}: s = mk(1,0,3,0,0);
			{7'd63, 4'd1}: s = mk(3,0,4,1,0);
			{7'd63, 4'd2}: s = mk(4,1,4,5,0);
			{7'd63, 4'd3}: s = mk(4,5,3,6,0);
			{7'd63, 4'd4}: s = mk(3,6,1,6,0);
			{7'd63, 4'd5}: s = mk(1,6,0,5,0);
			{7'd63, 4'd6}: s = mk(0,5,0,4,0);
			{7'd63, 4'd7}: s = mk(0,4,1,3,0);
			{7'd63, 4'd8}: s = mk(1,3,4,3,1);
			// punctuation
			{7'd64, 4'd0}: s = mk(1,3,3,3,1);
			{7'd65, 4'd0}: s = mk(2,0,2,1,1);
			{7'd66, 4'd0}: s = mk(2,1,1,-1,1);
			{7'd67, 4'd0}: s = mk(2,5,2,6,1);
			{7'd68, 4'd0}: s = mk(2,1,2,2,0);
			{7'd68, 4'd1}: s = mk(2,4,2,5,1);
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// File: sv/sgsg_seg_rom.sv
// glyph segment rom with registered read data
module sgsg_seg_rom (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [sgsg_pkg::ROM_ADDR_W-1:0]   rd_addr,
	output sgsg_pkg::seg_t                    rd_data
);
	import sgsg_pkg::*;

	// read data is registered when rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= seg_rom(rd_addr);
		end
	end

endmodule

// File: sv/stroke_glyph_segment_generator.sv
// top level: character in, stroke segments out, cursor advance
// Each accepted character is looked up in a glyph directory and its segments are read from a
// registered segment rom, then sent one per cycle, while the output is not stalled, through an
// output register. For each character, the transfer starts the first rom read, the read state
// follows, then the emit state sends one segment per unstalled cycle; no new character is
// taken until its last segment is loaded. The worst glyph has 15 segments. A space has no
// segments and leaves the sequencer idle. An output stall holds the emit state. The segment rom
// read port sets the pace of one segment per cycle while the output is not stalled.
// Unknown codes draw a box. The cursor advances by the configured advance (advance_q) after each
// character and saturates; line_start clears it first. No clearing pass is needed after reset.
module stroke_glyph_segment_generator #(
	parameter int CURSOR_WIDTH  = 20,
	parameter int FRACTION_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [7:0]                        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_code,
	input  logic                              line_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sgsg_pkg::XS_W-1:0]         start_x,
	output logic signed [sgsg_pkg::Y_W-1:0]   start_y,
	output logic [sgsg_pkg::XS_W-1:0]         end_x,
	output logic signed [sgsg_pkg::Y_W-1:0]   end_y,
	output logic                              last_segment
);
	import sgsg_pkg::*;

	localparam int SUM_W = CURSOR_WIDTH + 1;
	localparam logic [CURSOR_WIDTH-1:0] CUR_MAX = {CURSOR_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [7:0]                advance_q;
	logic [CURSOR_WIDTH-1:0]   cursor_q;
	logic [GLYPH_W-1:0]        glyph_q;
	logic [SEG_IDX_W-1:0]      idx_q;
	logic                      rd_en;
	logic [ROM_ADDR_W-1:0]     rd_addr;
	seg_t                      seg;
	dir_t                      dir;
	logic [CURSOR_WIDTH-1:0]   cur_eff;
	logic [SUM_W-1:0]          sum;
	logic                      out_free;

	assign dir = glyph_dir(char_code);
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;
	// rom read on accept (segment 0) or when the current segment leaves
	assign rd_en = (in_valid && in_ready) || (state_q == ST_EMIT && out_free);
	assign rd_addr = (state_q == ST_IDLE) ? {dir.glyph, {SEG_IDX_W{1'b0}}} : {glyph_q, idx_q};
	// line start only applies to a character being transferred
	assign cur_eff = (in_valid && in_ready && line_start) ? '0 : cursor_q;
	assign sum = SUM_W'(cur_eff) + SUM_W'(advance_q);

	sgsg_seg_rom u_rom (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (seg)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advance_q <= ADVANCE_RESET;
		end else if (cfg_we) begin
			advance_q <= cfg_wdata;
		end
	end

	// sequencer, cursor and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_q <= '0;
			glyph_q <= '0;
			idx_q <= '0;
			out_valid <= 1'b0;
			start_x <= '0;
			end_x <= '0;
			start_y <= '0;
			end_y <= '0;
			last_segment <= 1'b0;
		end else begin
			// a new segment is only loaded in emit, so clear outside it
			if (out_valid && out_ready && state_q != ST_EMIT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						glyph_q <= dir.glyph;
						idx_q <= SEG_IDX_W'(1);
						state_q <= (dir.nseg == 5'd0) ? ST_IDLE : ST_READ;
						if (dir.nseg == 5'd0) begin
							cursor_q <= sum[CURSOR_WIDTH] ? CUR_MAX : sum[CURSOR_WIDTH-1:0];
						end else begin
							// cursor used for x is the pre-advance value; keep it for the segments
							cursor_q <= cur_eff;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						start_x <= XS_W'(cursor_q) + XS_W'({seg.x0, {FRACTION_BITS{1'b0}}});
						end_x <= XS_W'(cursor_q) + XS_W'({seg.x1, {FRACTION_BITS{1'b0}}});
						start_y <= seg.y0;
						end_y <= seg.y1;
						last_segment <= seg.last;
						idx_q <= idx_q + 1'b1;
						if (seg.last) begin
							state_q <= ST_IDLE;
							cursor_q <= sum[CURSOR_WIDTH] ? CUR_MAX : sum[CURSOR_WIDTH-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no new character while segments of the last one are pending in the sequencer
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	// a stalled output holds the x coordinates of its segment
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(start_x) && $stable(end_x))
		else $error("output changed under stall");
	// leaving emit means the last segment was loaded
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free && seg.last |=> out_valid && last_segment)
		else $error("last segment missing");

endmodule
